// File: hdl/windowed_moving_average_assert.svh
// Assertion macros for the windowed moving average block.
// Used by the controller; no other dependencies.
`ifndef WINDOWED_MOVING_AVERAGE_ASSERT_SVH
`define WINDOWED_MOVING_AVERAGE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define WMA_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define WMA_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sma_pkg.sv
// Shared constants and controller/datapath handoff types for the moving average.
// No dependencies.
package sma_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_W           = 7;
  localparam logic [CFG_W-1:0] WIN_RESET = 7'd4;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // latch word, set up item
    logic mem_rd;    // read ring at current read address
    logic update;    // write sample, incremental sum
    logic scan_acc;  // add read data during recompute
    logic div_init;  // load divider
    logic div_step;  // one quotient bit
    logic load_out;  // move result to output register
  } sma_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic recompute; // sum must be rebuilt from the ring
    logic scan_done; // last element of recompute
    logic div_done;  // last quotient bit this cycle
    logic out_free;  // output register can take a word
  } sma_status_t;

endpackage

// File: hdl/sma_if.sv
// Valid/ready channel interfaces: input samples, results, configuration.
// Depends on sma_pkg.
interface sma_in_if
  import sma_pkg::*;
#(
  parameter int W = SAMPLE_BITS_DEF
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] sample;
  logic         last_sample;
  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface sma_out_if
  import sma_pkg::*;
#(
  parameter int W = SAMPLE_BITS_DEF
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] average;
  logic         last_out;
  modport source (output valid, output average, output last_out, input ready);
  modport sink   (input valid, input average, input last_out, output ready);
endinterface

interface sma_cfg_if
  import sma_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/windowed_moving_average.sv
// Windowed moving average, top level: FSM plus datapath.
// Depends on sma_pkg, the sma_*_if interfaces, sma_ctrl and sma_datapath.
//
// Takes one signed sample per word and returns one word per sample: the
// average of the most recent min(held, window) samples of the current
// sequence, truncated toward zero. A word with last_sample set ends the
// sequence; the history clears after its result. The window register
// (cfg_ch, 7 bits, reset 4) is clamped to 1..MAX_WINDOW. One word is in
// flight at a time. A word normally passes through accept, ring read,
// ring write with running-sum update, divider load, then the restoring
// divider at one quotient bit per cycle, then the move into the output
// register. The first word after a window write rebuilds the sum from the
// ring, with a read and an accumulate per averaged sample, on the single
// ring port. The output register lets a finished result wait while the
// block is ready for the next sample.
module windowed_moving_average
  import sma_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sma_in_if.sink     in_ch,
  sma_out_if.source  out_ch,
  sma_cfg_if.sink    cfg_ch
);

  sma_cmd_t    cmd;
  sma_status_t st;

  // sequencing
  sma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // ring, sum, divider, result register, window register
  sma_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_sample (in_ch.sample),
    .in_last   (in_ch.last_sample),
    .cmd       (cmd),
    .st        (st),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch)
  );

endmodule

// File: hdl/sma_ctrl.sv
// Sequencing FSM for the moving average: accept, ring update, optional
// recompute scan, serial divide, output load. Depends on sma_pkg.
module sma_ctrl
  import sma_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  sma_status_t st,
  output sma_cmd_t    cmd
);

  `include "windowed_moving_average_assert.svh"

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RDOLD = 8'b0000_0010,
    S_UPD   = 8'b0000_0100,
    S_SRD   = 8'b0000_1000,
    S_SACC  = 8'b0001_0000,
    S_DINIT = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_RDOLD;
        end
      end
      S_RDOLD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = st.recompute ? S_SRD : S_DINIT;
      end
      S_SRD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_SACC;
      end
      S_SACC: begin
        cmd.scan_acc = 1'b1;
        state_nxt    = st.scan_done ? S_DINIT : S_SRD;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  `WMA_ASSERT_NEXT(a_accept_reads, clk, rst_n, in_valid && in_ready, state_r == S_RDOLD,
                   "accepted word did not start ring read")
  `WMA_ASSERT_NEXT(a_div_to_out, clk, rst_n, state_r == S_DIV && st.div_done,
                   state_r == S_OUT, "divider finish did not reach output state")
  `WMA_ASSERT_NOW(a_load_free, clk, rst_n, cmd.load_out, st.out_free && state_r == S_OUT,
                  "result loaded while output register busy")

endmodule

// File: hdl/sma_datapath.sv
// Ring buffer, running sum, serial divider and output register.
// Depends on sma_pkg and the sma_out_if / sma_cfg_if interfaces.
module sma_datapath
  import sma_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_last,
  input  sma_cmd_t               cmd,
  output sma_status_t            st,
  sma_out_if.source              out_ch,
  sma_cfg_if.sink                cfg_ch
);

  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
  localparam int DCNT_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WINDOW);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(MAX_WINDOW - 1);

  typedef enum logic [1:0] {M_ADD, M_SUB, M_REC} mode_t;

  logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic [PTR_W-1:0]       raddr_r, pos_r, wptr_r;
  logic [CNT_W-1:0]       held_r, nprev_r, n_r, k_r;
  logic [SUM_W-1:0]       sum_r;
  logic [CFG_W-1:0]       win_r;
  logic                   dirty_r;
  logic [SAMPLE_BITS-1:0] smp_r;
  logic                   last_r;
  mode_t                  mode_r;
  logic [CNT_W-1:0]       rem_r;
  logic [SUM_W-1:0]       quo_r;
  logic [DCNT_W-1:0]      dcnt_r;
  logic                   neg_r;
  logic                   ovld_r;
  logic [SAMPLE_BITS-1:0] avg_r;
  logic                   olast_r;

  // item setup
  logic [CNT_W-1:0] eff_w, held_inc, n_new;
  logic [CNT_W:0]   drop_diff;
  logic [PTR_W-1:0] drop_addr;
  mode_t            mode_new;

  always_comb begin
    if (win_r == '0)                          eff_w = CNT_W'(1);
    else if (32'(win_r) > 32'(MAX_WINDOW))    eff_w = MAX_CNT;
    else                                      eff_w = CNT_W'(win_r);
    held_inc  = (held_r < MAX_CNT) ? held_r + CNT_W'(1) : held_r;
    n_new     = (eff_w < held_inc) ? eff_w : held_inc;
    drop_diff = (CNT_W+1)'(wptr_r) - (CNT_W+1)'(n_new);
    if (drop_diff[CNT_W]) drop_diff = drop_diff + (CNT_W+1)'(MAX_WINDOW);
    drop_addr = PTR_W'(drop_diff);
    if (dirty_r)                                              mode_new = M_REC;
    else if ((CNT_W+1)'(n_new) == (CNT_W+1)'(nprev_r) + 1'b1) mode_new = M_ADD;
    else if (n_new == nprev_r)                                mode_new = M_SUB;
    else                                                      mode_new = M_REC;
  end

  // sign-extended operands
  logic [SUM_W-1:0] smp_ext, rd_ext;
  assign smp_ext = {{(SUM_W-SAMPLE_BITS){smp_r[SAMPLE_BITS-1]}}, smp_r};
  assign rd_ext  = {{(SUM_W-SAMPLE_BITS){rd_data_r[SAMPLE_BITS-1]}}, rd_data_r};

  // restoring divide step
  logic [CNT_W:0]   rem_sh;
  logic             ge;
  logic [SUM_W-1:0] q_signed;
  assign rem_sh   = {rem_r, quo_r[SUM_W-1]};
  assign ge       = rem_sh >= {1'b0, n_r};
  assign q_signed = neg_r ? (~quo_r + 1'b1) : quo_r;

  assign st.recompute = (mode_r == M_REC);
  assign st.scan_done = (k_r + CNT_W'(1) == n_r);
  assign st.div_done  = (dcnt_r == DCNT_W'(SUM_W - 1));
  assign st.out_free  = !ovld_r || out_ch.ready;

  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = ovld_r;
  assign out_ch.average  = avg_r;
  assign out_ch.last_out = olast_r;

  // ring memory
  always_ff @(posedge clk) begin
    if (cmd.update) ring[pos_r] <= smp_r;
    if (cmd.mem_rd) rd_data_r <= ring[raddr_r];
  end

  // sequence control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= WIN_RESET;
      dirty_r <= 1'b0;
      held_r  <= '0;
      nprev_r <= '0;
      wptr_r  <= '0;
      sum_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        win_r   <= cfg_ch.data;
        dirty_r <= 1'b1;
      end
      if (cmd.accept) begin
        held_r  <= held_inc;
        nprev_r <= n_new;
        wptr_r  <= (wptr_r == LAST_PTR) ? '0 : wptr_r + PTR_W'(1);
      end
      if (cmd.update) begin
        case (mode_r)
          M_ADD:   sum_r <= sum_r + smp_ext;
          M_SUB:   sum_r <= sum_r + smp_ext - rd_ext;
          default: begin
            sum_r   <= '0;
            dirty_r <= 1'b0;
          end
        endcase
      end
      if (cmd.scan_acc) sum_r <= sum_r + rd_ext;
      if (cmd.load_out) begin
        ovld_r <= 1'b1;
        if (last_r) begin
          held_r  <= '0;
          nprev_r <= '0;
          wptr_r  <= '0;
          sum_r   <= '0;
        end
      end else if (out_ch.ready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  // per-item payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp_r   <= in_sample;
      last_r  <= in_last;
      pos_r   <= wptr_r;
      n_r     <= n_new;
      mode_r  <= mode_new;
      raddr_r <= drop_addr;
    end
    if (cmd.update) begin
      k_r     <= '0;
      raddr_r <= pos_r;
    end
    if (cmd.scan_acc) begin
      k_r     <= k_r + CNT_W'(1);
      raddr_r <= (raddr_r == '0) ? LAST_PTR : raddr_r - PTR_W'(1);
    end
    if (cmd.div_init) begin
      neg_r  <= sum_r[SUM_W-1];
      quo_r  <= sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
      rem_r  <= '0;
      dcnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? CNT_W'(rem_sh - {1'b0, n_r}) : CNT_W'(rem_sh);
      quo_r  <= {quo_r[SUM_W-2:0], ge};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.load_out) begin
      avg_r   <= q_signed[SAMPLE_BITS-1:0];
      olast_r <= last_r;
    end
  end

endmodule

// File: tb/average_checker.sv
// Checker for windowed_moving_average: watches the sample, result and window channels,
// predicts each result word from its own ring copy and compares in order.
// Depends on sma_pkg and the sma_*_if interfaces.
`timescale 1ns / 100ps

module average_checker
  import sma_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  sma_in_if    in_ch,
  sma_out_if   out_ch,
  sma_cfg_if   cfg_ch,
  output int   err_count,
  output int   outstanding,
  output int   results_seen
);

  localparam int DEPTH = MAX_WINDOW_DEF;
  localparam int PTR_W = $clog2(DEPTH);

  typedef struct packed {
    logic signed [SAMPLE_BITS_DEF-1:0] average;
    logic                              last_out;
  } avg_word_t;

  logic signed [SAMPLE_BITS_DEF-1:0] ring [DEPTH];
  logic [CFG_W-1:0]                  win_reg;
  logic [CFG_W-1:0]                  held;
  logic [PTR_W-1:0]                  wr_ptr;
  avg_word_t                         expected_avg_q [$];

  // store the sample, then average the min(held, window) newest entries
  function automatic avg_word_t next_average(logic signed [SAMPLE_BITS_DEF-1:0] s,
                                             logic last);
    avg_word_t        res;
    int               span;
    longint           total;
    longint           quot;
    logic [PTR_W-1:0] pos;
    ring[wr_ptr] = s;
    pos = wr_ptr;
    wr_ptr = wr_ptr + 1'b1;
    if (held < DEPTH) held = held + 1'b1;
    // zero acts as one, anything past the ring depth saturates
    span = (win_reg == 0) ? 1 : ((win_reg > DEPTH) ? DEPTH : int'(win_reg));
    if (span > held) span = held;
    total = 0;
    for (int k = 0; k < span; k++) begin
      total += ring[pos];
      pos = pos - 1'b1;
    end
    quot = total / span;  // truncates toward zero
    res.average = quot[SAMPLE_BITS_DEF-1:0];
    res.last_out = last;
    if (last) begin
      held = '0;
      wr_ptr = '0;
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    avg_word_t want;
    if (!rst_n) begin
      win_reg = WIN_RESET;
      held = '0;
      wr_ptr = '0;
      expected_avg_q.delete();
      outstanding = 0;
      err_count = 0;
      results_seen = 0;
    end else begin
      // result first: a word accepted this edge cannot be answered this edge
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_avg_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result word: expected none, got avg %0d last %0b",
                   $time, $signed(out_ch.average), out_ch.last_out);
        end else begin
          want = expected_avg_q.pop_front();
          if (out_ch.average !== want.average) begin
            err_count++;
            $display("%0t: average mismatch: expected %0d, got %0d",
                     $time, want.average, $signed(out_ch.average));
          end
          if (out_ch.last_out !== want.last_out) begin
            err_count++;
            $display("%0t: last_out mismatch: expected %0b, got %0b",
                     $time, want.last_out, out_ch.last_out);
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) win_reg = cfg_ch.data;
      if (in_ch.valid && in_ch.ready)
        expected_avg_q.push_back(next_average(in_ch.sample, in_ch.last_sample));
      outstanding = expected_avg_q.size();
    end
  end

endmodule

// File: tb/tb.sv
// Top of the moving average testbench: clock, reset, sample and window stimulus,
// result-side back-pressure and the verdict. Depends on sma_pkg, the sma_*_if
// interfaces, windowed_moving_average and average_checker.
`timescale 1ns / 100ps

module tb;
  import sma_pkg::*;

  localparam int N_RANDOM    = 600;  // random sample words after the directed part
  localparam int HOLD_CYCLES = 300;  // long output hold, well past one word's latency

  logic clk;
  logic rst_n;
  bit   calm;      // no idling on either side
  bit   hold_req;  // ask the result side for one long hold
  int   err_count, outstanding, results_seen;
  int   n_samples, n_sequences, n_writes;

  sma_in_if  #(.W(SAMPLE_BITS_DEF)) in_if  ();
  sma_out_if #(.W(SAMPLE_BITS_DEF)) out_if ();
  sma_cfg_if                        cfg_if ();

  windowed_moving_average dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  average_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_if),
    .out_ch       (out_if),
    .cfg_ch       (cfg_if),
    .err_count    (err_count),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop; a correct run needs a small fraction of this
  initial begin
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

  // Result side: random ready, except in calm stretches. On request it holds
  // off for HOLD_CYCLES, counted here, so the block backs up into its input.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 22);
      end
    end
  end

  // Offer one sample word, with random idle cycles ahead of it, and return at
  // the edge that takes it. valid stays high so back-to-back words have no gap.
  task automatic push_sample(logic [SAMPLE_BITS_DEF-1:0] s, logic last);
    while (!calm && $urandom_range(99) < 22) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.sample      <= s;
    in_if.last_sample <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    n_samples++;
    if (last) n_sequences++;
  endtask

  // Stop offering and wait until every predicted result word is back.
  // Checked on the falling edge so the checker's update at the rising edge is done.
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // Window writes only happen with the block drained. The sequence itself is
  // not ended, so a write may land in the middle of one.
  task automatic set_window(logic [CFG_W-1:0] w);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    n_writes++;
  endtask

  // Mostly legal windows, with zero and the saturating range mixed in.
  function automatic logic [CFG_W-1:0] pick_window();
    case ($urandom_range(9))
      0:       return CFG_W'(0);
      1:       return CFG_W'(1);
      2:       return CFG_W'(MAX_WINDOW_DEF);
      3:       return CFG_W'(127);
      4:       return CFG_W'($urandom_range(MAX_WINDOW_DEF + 1, 126));
      5, 6:    return CFG_W'($urandom_range(1, 8));
      default: return CFG_W'($urandom_range(1, MAX_WINDOW_DEF));
    endcase
  endfunction

  // Mostly short sequences; some run past the ring depth to exercise wrap.
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 16);
    else if (r < 93) return $urandom_range(17, MAX_WINDOW_DEF);
    else return $urandom_range(MAX_WINDOW_DEF + 1, 140);
  endfunction

  // Full-range values, rail values, and small values near zero where
  // truncation toward zero shows on both signs.
  function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 16'($urandom);
    else if (r < 70) begin
      case ($urandom_range(4))
        0:       return 16'h7FFF;
        1:       return 16'h8000;
        2:       return 16'hFFFF;
        3:       return 16'h0000;
        default: return 16'h0001;
      endcase
    end
    else return 16'($urandom_range(0, 400) - 200);
  endfunction

  initial begin
    int plen, seq_left, phase, target;
    in_if.valid       = 1'b0;
    in_if.sample      = '0;
    in_if.last_sample = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = WIN_RESET;
    calm              = 1'b0;
    hold_req          = 1'b0;
    rst_n             = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // Reset window of four: positive rail, window fills then slides.
    for (int i = 0; i < 5; i++) push_sample(16'h7FFF, i == 4);
    // negative rail
    push_sample(16'h8000, 1'b0);
    push_sample(16'h8000, 1'b1);
    // -1, then -3/2 must give -1 (toward zero), then 0
    push_sample(-16'sd1, 1'b0);
    push_sample(-16'sd2, 1'b0);
    push_sample(16'sd3, 1'b1);
    // one-word sequences, alternating bit patterns
    push_sample(16'h5555, 1'b1);
    push_sample(16'hAAAA, 1'b1);
    // window of zero behaves as one
    set_window(CFG_W'(0));
    push_sample(16'sd100, 1'b0);
    push_sample(-16'sd200, 1'b0);
    push_sample(16'sd300, 1'b1);
    // oversized window saturates; rails cancel to zero
    set_window(CFG_W'(127));
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h8000, 1'b1);
    // window changes mid-sequence: a grown window reaches back to older words
    set_window(CFG_W'(2));
    push_sample(16'sd10, 1'b0);
    push_sample(16'sd20, 1'b0);
    push_sample(16'sd30, 1'b0);
    set_window(CFG_W'(MAX_WINDOW_DEF));
    push_sample(16'sd40, 1'b0);
    set_window(CFG_W'(1));
    push_sample(16'sd50, 1'b1);

    // ---- random phases ----
    // Each phase starts drained, usually with a new window. Sequences run
    // across phase boundaries, so window changes fall inside them too.
    // Phase 1 carries the long output hold; phase 3 is a long calm stretch.
    target   = n_samples + N_RANDOM;
    seq_left = 0;
    phase    = 0;
    while (n_samples < target) begin
      if ($urandom_range(3) != 0) set_window(pick_window());
      else settle();
      calm = (phase == 3);
      if (phase == 1) hold_req = 1'b1;
      plen = calm ? 150 : $urandom_range(20, 60);
      repeat (plen) begin
        if (seq_left == 0) seq_left = pick_length();
        push_sample(pick_sample(), seq_left == 1);
        seq_left--;
      end
      calm = 1'b0;
      phase++;
    end

    // drain, then allow about one word's latency for anything stray
    settle();
    repeat (40) @(posedge clk);

    $display("summary: %0d samples, %0d closed sequences, %0d window writes,",
             n_samples, n_sequences, n_writes);
    $display("summary: %0d result words checked, incl. one %0d-cycle output hold",
             results_seen, HOLD_CYCLES);
    if (err_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
